// ----- design/multi_bracket_balance_checker_top_assert.svh -----
// assertion macros used by the bracket checker assertion file
`ifndef MULTI_BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH
`define MULTI_BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, ignored while reset is asserted
`define MBBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mbbc assertion failed");

// next-cycle implication, ignored while reset is asserted
`define MBBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mbbc assertion failed");

`endif

// ----- design/mbbc_pkg.sv -----
// ----------------------------------------------------------------------------
// mbbc_pkg
// Types, register indexes and reset values of the bracket balance checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mbbc_pkg;

  localparam int unsigned PairTypesDef = 4;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned KeySlots     = 4;
  localparam int unsigned BreakSlots   = 2;
  localparam int unsigned SymBits      = 8;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned CfgDataBits  = 32;
  localparam int unsigned OutDataBits  = 8;

  // "([{<", ")]}>", 4, ".", 1, "&", 1
  localparam logic [31:0] OpenKeysRst  = 32'h3C7B5B28;
  localparam logic [31:0] CloseKeysRst = 32'h3E7D5D29;
  localparam logic [2:0]  PairUseRst   = 3'd4;
  localparam logic [31:0] UnpSetRst    = 32'h0000002E;
  localparam logic [2:0]  UnpUseRst    = 3'd1;
  localparam logic [15:0] BrkSetRst    = 16'h0026;
  localparam logic [1:0]  BrkUseRst    = 2'd1;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_OPEN_KEYS  = 3'd0,
    CFG_CLOSE_KEYS = 3'd1,
    CFG_PAIR_USE   = 3'd2,
    CFG_UNP_SET    = 3'd3,
    CFG_UNP_USE    = 3'd4,
    CFG_BRK_SET    = 3'd5,
    CFG_BRK_USE    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_ILLEGAL   = 2'd1,
    ERR_UNMATCHED = 2'd2,
    ERR_UNCLOSED  = 2'd3
  } err_kind_e;

  typedef struct packed {
    err_kind_e kind;
    logic      ok;
  } result_t;

endpackage

`default_nettype wire

// ----- design/multi_bracket_balance_checker_top.sv -----
// ----------------------------------------------------------------------------
// multi_bracket_balance_checker_top
// Checks a dot-bracket string one character per transfer, per-type depths.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per transfer in tdata, tlast on the final
//   character of a string. For every tlast character one result leaves on
//   m_axis: tdata[0] structure_ok, tdata[2:1] error_kind (illegal character,
//   then unmatched closing, then unclosed opening), upper bits zero.
//   The cfg channel writes the key registers; it is always ready and must
//   only be used while no string is in flight.
//   A character is registered on input, then classified and the depth
//   counters updated from the input register; a tlast character also
//   loads the result register that drives m_axis. One character per
//   cycle is sustained by the single classify-and-count stage while
//   no tlast character waits on a stalled result.
//   Reset clears counters, sticky flags and both valid flags, and loads the
//   default keys "([{<" / ")]}>", unpaired "." and break "&".
//   When m_axis stalls with a result waiting, non-last characters keep
//   flowing; only a further tlast character waits in the input register,
//   and s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_bracket_balance_checker_top #(
  parameter int unsigned PAIR_TYPES = mbbc_pkg::PairTypesDef,
  parameter int unsigned COUNT_BITS = mbbc_pkg::CountBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mbbc_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [mbbc_pkg::CfgDataBits-1:0]   cfg_data_i,
  // character stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mbbc_pkg::SymBits-1:0]       s_axis_tdata,  // [7:0] symbol
  input  logic                               s_axis_tlast,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mbbc_pkg::OutDataBits-1:0]   m_axis_tdata   // [0] structure_ok, [2:1] error_kind
);
  import mbbc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  // configuration registers
  logic [31:0] open_keys_q, close_keys_q, unp_set_q;
  logic [15:0] brk_set_q;
  logic [2:0]  pair_use_q, unp_use_q;
  logic [1:0]  brk_use_q;

  // input register
  logic               in_vld_q;
  logic [SymBits-1:0] in_sym_q;
  logic               in_last_q;

  // string state
  logic [COUNT_BITS-1:0] cnt_q [PAIR_TYPES];
  logic [COUNT_BITS-1:0] cnt_d [PAIR_TYPES];
  logic                  ill_q, ill_d, uf_q, uf_d;

  // result register
  logic    out_vld_q, out_vld_d;
  result_t out_res_q;
  result_t res;

  logic go;
  logic s_xfer;

  logic [PAIR_TYPES-1:0] open_sel, close_sel;
  logic                  open_hit, close_hit, legal_other;
  logic                  ill_now, uf_now, unclosed;
  logic [COUNT_BITS-1:0] cnt_upd [PAIR_TYPES];
  logic                  ill_upd, uf_upd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_keys_q  <= OpenKeysRst;
      close_keys_q <= CloseKeysRst;
      pair_use_q   <= PairUseRst;
      unp_set_q    <= UnpSetRst;
      unp_use_q    <= UnpUseRst;
      brk_set_q    <= BrkSetRst;
      brk_use_q    <= BrkUseRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_OPEN_KEYS:  open_keys_q  <= cfg_data_i;
        CFG_CLOSE_KEYS: close_keys_q <= cfg_data_i;
        CFG_PAIR_USE:   pair_use_q   <= cfg_data_i[2:0];
        CFG_UNP_SET:    unp_set_q    <= cfg_data_i;
        CFG_UNP_USE:    unp_use_q    <= cfg_data_i[2:0];
        CFG_BRK_SET:    brk_set_q    <= cfg_data_i[15:0];
        CFG_BRK_USE:    brk_use_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // a last character needs a free result slot, others always proceed
  assign go            = in_vld_q && (!in_last_q || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || go;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_sym_q  <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // classify the character; lowest matching type wins, opening before closing
  always_comb begin
    open_sel    = '0;
    close_sel   = '0;
    open_hit    = 1'b0;
    close_hit   = 1'b0;
    legal_other = 1'b0;
    for (int k = 0; k < int'(PAIR_TYPES); k++) begin
      if (k < int'(KeySlots) && int'(pair_use_q) > k) begin
        if (!open_hit && open_keys_q[8*(k%KeySlots) +: 8] == in_sym_q) begin
          open_sel[k] = 1'b1;
          open_hit    = 1'b1;
        end
        if (!close_hit && close_keys_q[8*(k%KeySlots) +: 8] == in_sym_q) begin
          close_sel[k] = 1'b1;
          close_hit    = 1'b1;
        end
      end
    end
    for (int k = 0; k < int'(KeySlots); k++) begin
      if (int'(unp_use_q) > k && unp_set_q[8*k +: 8] == in_sym_q) begin
        legal_other = 1'b1;
      end
    end
    for (int k = 0; k < int'(BreakSlots); k++) begin
      if (int'(brk_use_q) > k && brk_set_q[8*k +: 8] == in_sym_q) begin
        legal_other = 1'b1;
      end
    end
  end

  always_comb begin
    uf_now   = 1'b0;
    unclosed = 1'b0;
    for (int k = 0; k < int'(PAIR_TYPES); k++) begin
      cnt_upd[k] = cnt_q[k];
      if (open_hit) begin
        if (open_sel[k] && cnt_q[k] != CntMax) begin
          cnt_upd[k] = cnt_q[k] + COUNT_BITS'(1);
        end
      end else if (close_sel[k]) begin
        if (cnt_q[k] == '0) begin
          uf_now = 1'b1;
        end else begin
          cnt_upd[k] = cnt_q[k] - COUNT_BITS'(1);
        end
      end
      if (cnt_upd[k] != '0) begin
        unclosed = 1'b1;
      end
    end
    ill_now = !open_hit && !close_hit && !legal_other;
    ill_upd = ill_q || ill_now;
    uf_upd  = uf_q || uf_now;

    if (ill_upd) begin
      res.kind = ERR_ILLEGAL;
    end else if (uf_upd) begin
      res.kind = ERR_UNMATCHED;
    end else if (unclosed) begin
      res.kind = ERR_UNCLOSED;
    end else begin
      res.kind = ERR_NONE;
    end
    res.ok = (res.kind == ERR_NONE);
  end

  // state for the next character, cleared after the last one
  always_comb begin
    for (int k = 0; k < int'(PAIR_TYPES); k++) begin
      cnt_d[k] = cnt_q[k];
    end
    ill_d = ill_q;
    uf_d  = uf_q;
    if (go) begin
      for (int k = 0; k < int'(PAIR_TYPES); k++) begin
        cnt_d[k] = in_last_q ? '0 : cnt_upd[k];
      end
      ill_d = in_last_q ? 1'b0 : ill_upd;
      uf_d  = in_last_q ? 1'b0 : uf_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(PAIR_TYPES); k++) begin
        cnt_q[k] <= '0;
      end
      ill_q <= 1'b0;
      uf_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ill_q <= ill_d;
      uf_q  <= uf_d;
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q && !m_axis_tready;
    if (go && in_last_q) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && in_last_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataBits - $bits(result_t))'(0), out_res_q.kind, out_res_q.ok};

endmodule

`default_nettype wire

// ----- design/mbbc_checker.sv -----
// ----------------------------------------------------------------------------
// mbbc_checker
// Port-level assertions for the bracket balance checker, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_bracket_balance_checker_top_assert.svh"

module mbbc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o,
  input logic [mbbc_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input logic [mbbc_pkg::CfgDataBits-1:0] cfg_data_i,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [mbbc_pkg::SymBits-1:0]     s_axis_tdata,  // [7:0] symbol
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mbbc_pkg::OutDataBits-1:0] m_axis_tdata   // [0] structure_ok, [2:1] error_kind
);
  import mbbc_pkg::*;

  // structure_ok agrees with the error code
  `MBBC_ASSERT_NOW(a_ok_matches_kind, m_axis_tvalid,
    m_axis_tdata[0] == (m_axis_tdata[2:1] == ERR_NONE))

  // pad bits above the result stay zero
  `MBBC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:3] == 5'd0)

  // input back-pressure only comes from a waiting result
  `MBBC_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // a stalled result holds
  `MBBC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind multi_bracket_balance_checker_top mbbc_checker u_mbbc_checker (.*);

`default_nettype wire

// ----- test/bracket_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bracket_result_checker
// Watches the key, character and result channels of the bracket checker,
// keeps its own per-type depth counters and error flags, and compares every
// result transfer with the oldest predicted verdict.
// ----------------------------------------------------------------------------

module bracket_result_checker #(
  parameter int unsigned PAIR_TYPES = mbbc_pkg::PairTypesDef,
  parameter int unsigned COUNT_BITS = mbbc_pkg::CountBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [mbbc_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [mbbc_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [mbbc_pkg::SymBits-1:0]     s_axis_tdata,  // [7:0] symbol
  input  logic                             s_axis_tlast,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [mbbc_pkg::OutDataBits-1:0] m_axis_tdata,  // [0] structure_ok, [2:1] error_kind
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);

  import mbbc_pkg::*;

  typedef struct {
    logic [31:0] open_keys;
    logic [31:0] close_keys;
    logic [2:0]  pair_use;
    logic [31:0] unp_set;
    logic [2:0]  unp_use;
    logic [15:0] brk_set;
    logic [1:0]  brk_use;
  } key_cfg_t;

  key_cfg_t              keys;
  logic [COUNT_BITS-1:0] depth [PAIR_TYPES];
  logic                  illegal_seen;
  logic                  unmatched_seen;
  result_t               verdict_q[$];
  result_t               want;

  initial fail_count_o = 0;
  initial pending_o = 0;

  task automatic report_mismatch(string what, int unsigned got, int unsigned wanted);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
    fail_count_o++;
  endtask

  function automatic bit key_listed(logic [31:0] set, int unsigned used, int unsigned slots,
                                    logic [7:0] sym);
    int unsigned n;
    n = (used > slots) ? slots : used;
    for (int unsigned k = 0; k < n; k++) begin
      if (set[8 * k +: 8] == sym) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_string();
    for (int unsigned k = 0; k < PAIR_TYPES; k++) depth[k] = '0;
    illegal_seen = 1'b0;
    unmatched_seen = 1'b0;
  endfunction

  // classify one character, update the depths and queue a verdict on tlast
  function automatic void take_symbol(logic [7:0] sym, logic last);
    int unsigned n;
    int          open_t;
    int          close_t;
    bit          unclosed;
    result_t     verdict;
    n = (keys.pair_use > KeySlots) ? KeySlots : 32'(keys.pair_use);
    if (n > PAIR_TYPES) n = PAIR_TYPES;
    open_t = -1;
    close_t = -1;
    for (int unsigned k = 0; k < n; k++) begin
      if (open_t < 0 && keys.open_keys[8 * k +: 8] == sym) open_t = int'(k);
      if (close_t < 0 && keys.close_keys[8 * k +: 8] == sym) close_t = int'(k);
    end
    if (open_t >= 0) begin
      if (depth[open_t] != '1) depth[open_t] = depth[open_t] + 1'b1;
    end else if (close_t >= 0) begin
      if (depth[close_t] == '0) unmatched_seen = 1'b1;
      else depth[close_t] = depth[close_t] - 1'b1;
    end else if (!key_listed(keys.unp_set, 32'(keys.unp_use), KeySlots, sym) &&
                 !key_listed({16'h0, keys.brk_set}, 32'(keys.brk_use), BreakSlots, sym)) begin
      illegal_seen = 1'b1;
    end
    if (!last) return;
    unclosed = 1'b0;
    for (int unsigned k = 0; k < PAIR_TYPES; k++) begin
      if (depth[k] != '0) unclosed = 1'b1;
    end
    if (illegal_seen) verdict.kind = ERR_ILLEGAL;
    else if (unmatched_seen) verdict.kind = ERR_UNMATCHED;
    else if (unclosed) verdict.kind = ERR_UNCLOSED;
    else verdict.kind = ERR_NONE;
    verdict.ok = (verdict.kind == ERR_NONE);
    verdict_q = {verdict_q, verdict};
    clear_string();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys.open_keys = OpenKeysRst;
      keys.close_keys = CloseKeysRst;
      keys.pair_use = PairUseRst;
      keys.unp_set = UnpSetRst;
      keys.unp_use = UnpUseRst;
      keys.brk_set = BrkSetRst;
      keys.brk_use = BrkUseRst;
      clear_string();
      verdict_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_OPEN_KEYS:  keys.open_keys = cfg_data_i;
          CFG_CLOSE_KEYS: keys.close_keys = cfg_data_i;
          CFG_PAIR_USE:   keys.pair_use = cfg_data_i[2:0];
          CFG_UNP_SET:    keys.unp_set = cfg_data_i;
          CFG_UNP_USE:    keys.unp_use = cfg_data_i[2:0];
          CFG_BRK_SET:    keys.brk_set = cfg_data_i[15:0];
          CFG_BRK_USE:    keys.brk_use = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no string pending", 32'(m_axis_tdata), 0);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want.ok)
            report_mismatch("structure_ok", 32'(m_axis_tdata[0]), 32'(want.ok));
          if (m_axis_tdata[2:1] !== want.kind)
            report_mismatch("error_kind", 32'(m_axis_tdata[2:1]), 32'(want.kind));
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_symbol(s_axis_tdata, s_axis_tlast);
    end
    pending_o = verdict_q.size();
  end

endmodule

// ----- test/tb_multi_bracket_balance_checker_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_bracket_balance_checker_top
// Drives key settings and dot-bracket strings into the bracket checker:
// a few directed strings for each error kind and for the key extremes, then
// phases of random well-formed, broken and noise strings under changing keys,
// with random gaps and stalls on both streams. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb_multi_bracket_balance_checker_top;

  import mbbc_pkg::*;

  localparam int unsigned ItemTarget = 1550;
  localparam int unsigned PhaseItems = 160;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned DrainCycles = 4;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SymBits-1:0]     s_axis_tdata = '0;  // [7:0] symbol
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;       // [0] structure_ok, [2:1] error_kind

  int unsigned fail_count;
  int unsigned pending;

  // stimulus copy of the keys, used only to build strings
  logic [31:0] open_w;
  logic [31:0] close_w;
  logic [2:0]  pair_n;
  logic [7:0]  fill_q[$];

  int unsigned sent_items = 0;
  int unsigned hold_req = 0;
  bit          no_idle = 1'b0;
  int unsigned quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  multi_bracket_balance_checker_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bracket_result_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // result side: random stalls, quiet stretches and requested long hold-offs
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == QuietLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int unsigned live_pairs();
    return (pair_n > KeySlots) ? KeySlots : 32'(pair_n);
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_keys(logic [31:0] opn, logic [31:0] cls, logic [2:0] pn,
                          logic [31:0] us, logic [2:0] un, logic [15:0] bs, logic [1:0] bn);
    int unsigned nu;
    int unsigned nb;
    open_w = opn;
    close_w = cls;
    pair_n = pn;
    nu = (un > KeySlots) ? KeySlots : 32'(un);
    nb = (bn > BreakSlots) ? BreakSlots : 32'(bn);
    fill_q.delete();
    for (int unsigned k = 0; k < nu; k++) fill_q = {fill_q, us[8 * k +: 8]};
    for (int unsigned k = 0; k < nb; k++) fill_q = {fill_q, bs[8 * k +: 8]};
    write_reg(CFG_OPEN_KEYS, opn);
    write_reg(CFG_CLOSE_KEYS, cls);
    write_reg(CFG_PAIR_USE, 32'(pn));
    write_reg(CFG_UNP_SET, us);
    write_reg(CFG_UNP_USE, 32'(un));
    write_reg(CFG_BRK_SET, 32'(bs));
    write_reg(CFG_BRK_USE, 32'(bn));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_char(logic [7:0] sym, logic last);
    if (!no_idle && $urandom_range(0, 99) < 16) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= sym;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  task automatic send_text(string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
  endtask

  // stop offering and wait until every verdict is back and the block is quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // properly nested string, optionally with one character replaced at random
  task automatic send_balanced(int unsigned len, bit corrupt);
    int unsigned n;
    int unsigned bad_at;
    int unsigned t;
    int unsigned nest[$];
    logic [7:0]  sym;
    n = live_pairs();
    bad_at = corrupt ? $urandom_range(0, len - 1) : len;
    for (int unsigned i = 0; i < len; i++) begin
      if (n != 0 && nest.size() != 0 &&
          (len - i == nest.size() || $urandom_range(0, 2) == 0)) begin
        t = nest.pop_back();
        sym = close_w[8 * t +: 8];
      end else if (n != 0 && len - i >= nest.size() + 2 && $urandom_range(0, 1) == 1) begin
        t = $urandom_range(0, n - 1);
        nest = {nest, t};
        sym = open_w[8 * t +: 8];
      end else if (fill_q.size() != 0) begin
        sym = fill_q[$urandom_range(0, fill_q.size() - 1)];
      end else if (n != 0 && nest.size() != 0) begin
        t = nest.pop_back();
        sym = close_w[8 * t +: 8];
      end else begin
        sym = 8'($urandom_range(0, 255));
      end
      if (i == bad_at) sym = 8'($urandom_range(0, 255));
      send_char(sym, i == len - 1);
    end
  endtask

  // any legal character in any order
  task automatic send_alphabet(int unsigned len);
    logic [7:0] letters[$];
    letters = fill_q;
    for (int unsigned k = 0; k < live_pairs(); k++) begin
      letters = {letters, open_w[8 * k +: 8], close_w[8 * k +: 8]};
    end
    for (int unsigned i = 0; i < len; i++) begin
      if (letters.size() == 0) send_char(8'($urandom_range(0, 255)), i == len - 1);
      else send_char(letters[$urandom_range(0, letters.size() - 1)], i == len - 1);
    end
  endtask

  task automatic send_noise(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_char(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  function automatic logic [7:0] fresh_byte(ref bit used [256]);
    int unsigned b;
    do b = $urandom_range(0, 255); while (used[b]);
    used[b] = 1'b1;
    return 8'(b);
  endfunction

  initial begin
    bit          used [256];
    logic [31:0] w [4];
    int unsigned phase;
    int unsigned phase_start;
    int unsigned len;
    int unsigned pick;

    open_w = OpenKeysRst;
    close_w = CloseKeysRst;
    pair_n = PairUseRst;
    fill_q = '{UnpSetRst[7:0], BrkSetRst[7:0]};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset keys: each error kind and the precedence between them
    send_text("()");
    send_text(")");
    send_text("((");
    send_text("a");
    send_text("x)");
    send_text(")(");
    send_text("[{<.&>}]");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    settle();

    // open keys zero, close keys all ones, nothing enabled: every character is illegal
    set_keys(32'h0, 32'hFFFF_FFFF, 3'd0, 32'h0, 3'd0, 16'h0, 2'd0);
    send_text("(");
    send_char(8'h00, 1'b1);
    settle();

    // all ones but the closing keys, counts above range act as the maximum
    set_keys(32'hFFFF_FFFF, 32'h0, 3'd7, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 2'd3);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'h00, 1'b1);
    settle();

    // overlapping keys: opening wins over closing, lowest type wins
    set_keys(32'h2828_2828, 32'h2928_2929, 3'd4, 32'h2829_2A2B, 3'd4, 16'h2829, 2'd2);
    send_text("()");
    send_text(")");
    send_text("*");
    settle();

    for (phase = 0; sent_items < ItemTarget; phase++) begin
      case (phase % 4)
        0: begin
          set_keys(OpenKeysRst, CloseKeysRst, PairUseRst, UnpSetRst, UnpUseRst, BrkSetRst,
                   BrkUseRst);
        end
        1: begin
          used = '{default: 1'b0};
          for (int k = 0; k < 4; k++) begin
            w[k] = {fresh_byte(used), fresh_byte(used), fresh_byte(used), fresh_byte(used)};
          end
          set_keys(w[0], w[1], 3'($urandom_range(1, 4)), w[2], 3'($urandom_range(0, 4)),
                   w[3][15:0], 2'($urandom_range(0, 2)));
        end
        2: begin
          // few distinct bytes, so keys collide across types and sets
          for (int k = 0; k < 4; k++) begin
            w[k] = {8'($urandom_range(8'h28, 8'h2B)), 8'($urandom_range(8'h28, 8'h2B)),
                    8'($urandom_range(8'h28, 8'h2B)), 8'($urandom_range(8'h28, 8'h2B))};
          end
          set_keys(w[0], w[1], 3'($urandom_range(1, 7)), w[2], 3'($urandom_range(0, 7)),
                   w[3][15:0], 2'($urandom_range(0, 3)));
        end
        default: begin
          set_keys($urandom, $urandom, 3'($urandom_range(0, 7)), $urandom,
                   3'($urandom_range(0, 7)), 16'($urandom_range(0, 16'hFFFF)),
                   2'($urandom_range(0, 3)));
        end
      endcase
      no_idle = (phase == 1);
      if (phase == 0) begin
        // long receiver hold-off while a deep nest and further strings keep coming
        hold_req++;
        for (int i = 0; i < 120; i++) send_char(open_w[7:0], 1'b0);
        for (int i = 0; i < 120; i++) send_char(close_w[7:0], i == 119);
      end
      phase_start = sent_items;
      while (sent_items - phase_start < PhaseItems && sent_items < ItemTarget) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        pick = $urandom_range(0, 99);
        if (pick < 65) send_balanced(len, 1'b0);
        else if (pick < 75) send_balanced(len, 1'b1);
        else if (pick < 90) send_alphabet(len);
        else send_noise(len);
      end
      settle();
    end
    no_idle = 1'b0;

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
